// ===== rtl/core/bmp24_pkg.sv =====
// Package for the BMP 24-bit palette pixel mapper.
// Holds header offsets, config register indexes and the palette match function.
// No dependencies.
package bmp24_pkg;

  localparam int unsigned HeaderLen = 54;
  localparam logic [5:0] HdrWidthLo  = 6'h12;
  localparam logic [5:0] HdrWidthHi  = 6'h13;
  localparam logic [5:0] HdrHeightLo = 6'h16;
  localparam logic [5:0] HdrHeightHi = 6'h17;
  localparam logic [5:0] HdrLast     = 6'(HeaderLen - 1);

  localparam logic CfgOriginX = 1'b0;
  localparam logic CfgOriginY = 1'b1;

  typedef enum logic [1:0] {
    PhaseBlue  = 2'd0,
    PhaseGreen = 2'd1,
    PhaseRed   = 2'd2
  } phase_e;

  typedef struct packed {
    logic       hit;
    logic [7:0] idx;
  } match_t;

  // Web-safe cube level test: 0x00,0x33,..,0xFF; returns level 0..5
  function automatic logic [2:0] cube_level(input logic [7:0] v, output logic ok);
    logic [2:0] lvl;
    begin
      ok  = 1'b1;
      lvl = 3'd0;
      case (v)
        8'h00: lvl = 3'd0;
        8'h33: lvl = 3'd1;
        8'h66: lvl = 3'd2;
        8'h99: lvl = 3'd3;
        8'hCC: lvl = 3'd4;
        8'hFF: lvl = 3'd5;
        default: ok = 1'b0;
      endcase
      return lvl;
    end
  endfunction

  // First-match palette lookup. Entries 0..47 are irregular; 48..255 are the
  // 6x6x6 cube minus the eight corners, in green-major, red, blue order.
  function automatic match_t palette_match(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
    match_t m;
    logic [23:0] k;
    logic okb, okg, okr;
    logic [2:0] lb, lg, lr;
    logic [8:0] pos;
    logic [7:0] base;
    begin
      m  = '{hit: 1'b1, idx: 8'd0};
      k  = {b, g, r};
      lb = cube_level(b, okb);
      lg = cube_level(g, okg);
      lr = cube_level(r, okr);
      case (k)
        24'h000000: m.idx = 8'd0;
        24'h800000: m.idx = 8'd1;
        24'h008000: m.idx = 8'd2;
        24'hFFFFFF: m.idx = 8'd3;
        24'h000080: m.idx = 8'd4;
        24'h800080: m.idx = 8'd5;
        24'h004080: m.idx = 8'd6;
        24'hC0C0C0: m.idx = 8'd7;
        24'h808080: m.idx = 8'd8;
        24'hFF0000: m.idx = 8'd9;
        24'h00FF00: m.idx = 8'd10;
        24'hFFFF00: m.idx = 8'd11;
        24'h0000FF: m.idx = 8'd12;
        24'hFF00FF: m.idx = 8'd13;
        24'h00FFFF: m.idx = 8'd14;
        24'h202020: m.idx = 8'd16;
        24'h008080: m.idx = 8'd17;
        24'hDFDFDF: m.idx = 8'd18;
        24'hA0A0A0: m.idx = 8'd19;
        24'hDDE6EA: m.idx = 8'd20;
        24'hBBCCD5: m.idx = 8'd21;
        24'h688DA2: m.idx = 8'd22;
        24'h804000: m.idx = 8'd23;
        24'hFF8000: m.idx = 8'd24;
        24'h80FF00: m.idx = 8'd25;
        24'h000040: m.idx = 8'd26;
        24'h400040: m.idx = 8'd27;
        24'h800040: m.idx = 8'd28;
        24'h808040: m.idx = 8'd29;
        24'h400080: m.idx = 8'd30;
        24'hFF0080: m.idx = 8'd31;
        24'h404080: m.idx = 8'd32;
        24'h408080: m.idx = 8'd33;
        24'hC08080: m.idx = 8'd34;
        24'hFF8080: m.idx = 8'd35;
        24'h00FF80: m.idx = 8'd36;
        24'hFFFF80: m.idx = 8'd37;
        24'hF0C8A4: m.idx = 8'd38;
        24'hC0DCC0: m.idx = 8'd39;
        24'h8000FF: m.idx = 8'd40;
        24'h0080FF: m.idx = 8'd41;
        24'hC080FF: m.idx = 8'd42;
        24'hFF80FF: m.idx = 8'd43;
        24'h8080FF: m.idx = 8'd44;
        24'h80FFFF: m.idx = 8'd45;
        24'hF0FBFF: m.idx = 8'd46;
        24'hE8FFFF: m.idx = 8'd47;
        default: begin
          // Full-cube position g*36 + r*6 + b, then drop the corners before it
          pos = 9'({lg, 5'd0}) + 9'({lg, 2'd0}) + 9'({lr, 2'd0}) + 9'({lr, 1'd0})
              + 9'(lb);
          if ((lg == 3'd0 || lg == 3'd5) && (lr == 3'd0 || lr == 3'd5)) begin
            // Corner rows only hold the four middle blues
            m.hit = okb && okg && okr && lb != 3'd0 && lb != 3'd5;
          end else begin
            m.hit = okb && okg && okr;
          end
          // corners passed: g=0 gives 1, 2 or 3 as r is 0, middle or 5;
          // middle g gives 4; g=5 gives 5, 6 or 7 the same way
          if (lg == 3'd0) begin
            base = (lr == 3'd5) ? 8'd3 : 8'd1;
          end else if (lg == 3'd5) begin
            base = (lr == 3'd5) ? 8'd7 : 8'd5;
          end else begin
            base = 8'd4;
          end
          if (lg == 3'd0 && lr != 3'd0 && lr != 3'd5) base = 8'd2;
          if (lg == 3'd5 && lr != 3'd0 && lr != 3'd5) base = 8'd6;
          m.idx = 8'(pos - 9'(base) + 9'd48);
          if (!m.hit) m.idx = 8'd0;
        end
      endcase
      return m;
    end
  endfunction

endpackage

// ===== rtl/core/bmp24_palette_pixel_mapper_top.sv =====
// BMP 24-bit palette pixel mapper, top level.
// Parses the byte stream, matches pixels and registers one result per pixel.
// Depends on bmp24_pkg.
//
//  channel | signals                                        | direction
//  in      | in_valid_i, in_ready_o, data_byte_i, start_of_file_i | to block
//  out     | out_valid_o, out_ready_i, pos_x_o .. last_pixel_o | from block
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i               | to block
//
// One byte is accepted per cycle while no held result stalls input; the palette
// match is constant compare logic between the parse registers and the result register.
// A pixel result becomes valid in the cycle after its red byte is accepted.
// Input is taken whenever the result register is empty or being drained.
// Reset clears parse state; the block idles until a start-of-file byte.
module bmp24_palette_pixel_mapper_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               start_of_file_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] pos_x_o,
  output logic signed [17:0] pos_y_o,
  output logic [7:0]         color_index_o,
  output logic               in_palette_o,
  output logic               last_pixel_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import bmp24_pkg::*;

  logic [15:0] origin_x_q, origin_y_q;
  logic [5:0]  hdr_cnt_q, hdr_cnt_d;
  logic        hdr_done_q, hdr_done_d;
  logic [15:0] width_q, width_d, height_q, height_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  blue_q, blue_d, green_q, green_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic        idle_q, idle_d;
  logic        emit;
  logic        accept;
  match_t      match;
  logic        out_valid_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgOriginX) origin_x_q <= cfg_wdata_i;
      if (cfg_idx_i == CfgOriginY) origin_y_q <= cfg_wdata_i;
    end
  end

  // Parse next-state
  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    hdr_done_d = hdr_done_q;
    width_d    = width_q;
    height_d   = height_q;
    phase_d    = phase_q;
    blue_d     = blue_q;
    green_d    = green_q;
    col_d      = col_q;
    row_d      = row_q;
    idle_d     = idle_q;
    emit       = 1'b0;
    if (start_of_file_i) begin
      hdr_cnt_d  = '0;
      hdr_done_d = 1'b0;
      phase_d    = PhaseBlue;
      col_d      = '0;
      row_d      = '0;
      idle_d     = 1'b0;
    end
    if (!idle_d) begin
      if (!hdr_done_d) begin
        case (hdr_cnt_d)
          HdrWidthLo:  width_d[7:0]   = data_byte_i;
          HdrWidthHi:  width_d[15:8]  = data_byte_i;
          HdrHeightLo: height_d[7:0]  = data_byte_i;
          HdrHeightHi: height_d[15:8] = data_byte_i;
          default: ;
        endcase
        if (hdr_cnt_d == HdrLast) begin
          hdr_done_d = 1'b1;
          phase_d    = PhaseBlue;
          col_d      = '0;
          if (width_d == '0 || height_d == '0) idle_d = 1'b1;
          else row_d = height_d - 16'd1;
        end else begin
          hdr_cnt_d = hdr_cnt_d + 6'd1;
        end
      end else begin
        case (phase_d)
          PhaseBlue: begin
            blue_d  = data_byte_i;
            phase_d = PhaseGreen;
          end
          PhaseGreen: begin
            green_d = data_byte_i;
            phase_d = PhaseRed;
          end
          default: begin
            phase_d = PhaseBlue;
            emit    = 1'b1;
            if (col_d + 16'd1 == width_q) begin
              col_d = '0;
              if (row_d == '0) idle_d = 1'b1;
              else row_d = row_d - 16'd1;
            end else begin
              col_d = col_d + 16'd1;
            end
          end
        endcase
      end
    end
  end

  assign match = palette_match(blue_q, green_q, data_byte_i);

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q  <= '0;
      hdr_done_q <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      phase_q    <= PhaseBlue;
      blue_q     <= '0;
      green_q    <= '0;
      col_q      <= '0;
      row_q      <= '0;
      idle_q     <= 1'b1;
    end else if (accept) begin
      hdr_cnt_q  <= hdr_cnt_d;
      hdr_done_q <= hdr_done_d;
      width_q    <= width_d;
      height_q   <= height_d;
      phase_q    <= phase_d;
      blue_q     <= blue_d;
      green_q    <= green_d;
      col_q      <= col_d;
      row_q      <= row_d;
      idle_q     <= idle_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      pos_x_o       <= 18'(signed'(origin_x_q)) + 18'(col_q);
      pos_y_o       <= 18'(signed'(origin_y_q)) + 18'(row_q);
      color_index_o <= match.idx;
      in_palette_o  <= match.hit;
      last_pixel_o  <= (col_q == width_q - 16'd1) && (row_q == '0);
    end
  end

`ifndef SYNTH
  // A pixel result only comes from an accepted transaction
  a_out_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(accept)) else $error("result without input");
  // A held result blocks input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("overrun");
  // Last pixel sends the parser idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_pixel_o && $rose(out_valid_o)) |-> idle_q || $past(start_of_file_i))
    else $error("not idle after last pixel");
`endif

endmodule
